@@ rtl/core/ookpw_pkg.sv @@
// Shared types, constants and helpers for the OOK pulse-width frame decoder.
// No dependencies; every other file of the core refers to it by scoped names.
`default_nettype none

package ookpw_pkg;

    // Field widths
    localparam int DATA_WIDTH     = 64;
    localparam int DURATION_WIDTH = 24;
    localparam int TIME_WIDTH     = 16;
    localparam int COUNT_WIDTH    = 8;
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 24;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_SHORT_TIME      = 3'd0,
        CFG_LONG_TIME       = 3'd1,
        CFG_SHORT_TOLERANCE = 3'd2,
        CFG_LONG_TOLERANCE  = 3'd3,
        CFG_PREAMBLE_WINDOW = 3'd4,
        CFG_GAP_THRESHOLD   = 3'd5,
        CFG_MIN_BITS        = 3'd6
    } cfg_idx_t;

    // Reset values of the configuration registers
    localparam logic [TIME_WIDTH-1:0]     RST_SHORT_TIME      = 16'd390;
    localparam logic [TIME_WIDTH-1:0]     RST_LONG_TIME       = 16'd777;
    localparam logic [TIME_WIDTH-1:0]     RST_SHORT_TOLERANCE = 16'd100;
    localparam logic [TIME_WIDTH-1:0]     RST_LONG_TOLERANCE  = 16'd300;
    localparam logic [DURATION_WIDTH-1:0] RST_PREAMBLE_WINDOW = 24'd57500;
    localparam logic [DURATION_WIDTH-1:0] RST_GAP_THRESHOLD   = 24'd4000;
    localparam logic [COUNT_WIDTH-1:0]    RST_MIN_BITS        = 8'd24;

    typedef struct packed {
        logic [TIME_WIDTH-1:0]     short_time;
        logic [TIME_WIDTH-1:0]     long_time;
        logic [TIME_WIDTH-1:0]     short_tolerance;
        logic [TIME_WIDTH-1:0]     long_tolerance;
        logic [DURATION_WIDTH-1:0] preamble_window;
        logic [DURATION_WIDTH-1:0] gap_threshold;
        logic [COUNT_WIDTH-1:0]    min_bits;
    } cfg_t;

    // Pulse width matches for the current pulse and the stored low half
    typedef struct packed {
        logic pre_arm;     // duration near short_time within preamble_window
        logic dur_long;    // duration near long_time
        logic dur_short;   // duration near short_time
        logic low_long;    // last low half near long_time
        logic low_short;   // last low half near short_time
        logic gap;         // duration at or above gap_threshold
    } match_t;

    // Parser states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ARMED = 4'b0010,
        ST_SAVE  = 4'b0100,
        ST_CHECK = 4'b1000
    } state_t;

    // |a - b| < tol, one extra bit so the difference never wraps
    function automatic logic near(
        input logic [DURATION_WIDTH-1:0] a,
        input logic [DURATION_WIDTH-1:0] b,
        input logic [DURATION_WIDTH-1:0] tol
    );
        logic [DURATION_WIDTH:0] diff;
        if (a >= b)
            diff = {1'b0, a} - {1'b0, b};
        else
            diff = {1'b0, b} - {1'b0, a};
        return diff < {1'b0, tol};
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/ookpw_ifs.sv @@
// Valid/ready channel interfaces: pulse input, frame result, register writes.
// Depends on ookpw_pkg for field widths.
`default_nettype none

interface ookpw_pulse_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    level;
    logic [ookpw_pkg::DURATION_WIDTH-1:0]    duration;

    modport source (output valid, output level, output duration, input ready);
    modport sink   (input valid, input level, input duration, output ready);
endinterface

interface ookpw_frame_if;
    logic                                    valid;
    logic                                    ready;
    logic [ookpw_pkg::DATA_WIDTH-1:0]        frame_data;
    logic [ookpw_pkg::COUNT_WIDTH-1:0]       frame_bits;

    modport source (output valid, output frame_data, output frame_bits, input ready);
    modport sink   (input valid, input frame_data, input frame_bits, output ready);
endinterface

interface ookpw_cfg_if;
    logic                                    valid;
    logic                                    ready;
    logic [ookpw_pkg::CFG_IDX_WIDTH-1:0]     index;
    logic [ookpw_pkg::CFG_DATA_WIDTH-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ookpw_cfg_regs.sv @@
// Configuration register file of the decoder, written over the config channel.
// Depends on ookpw_pkg and ookpw_cfg_if.
`default_nettype none

module ookpw_cfg_regs
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    ookpw_cfg_if.sink            cfg,
    output ookpw_pkg::cfg_t      cfg_values
);

    ookpw_pkg::cfg_t cfg_reg;
    ookpw_pkg::cfg_t cfg_next;
    logic            wr_en;

    // Writes are always taken
    assign cfg.ready  = 1'b1;
    assign wr_en      = cfg.valid;
    assign cfg_values = cfg_reg;

    // Register decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg.index)
                ookpw_pkg::CFG_SHORT_TIME:
                    cfg_next.short_time = cfg.data[ookpw_pkg::TIME_WIDTH-1:0];
                ookpw_pkg::CFG_LONG_TIME:
                    cfg_next.long_time = cfg.data[ookpw_pkg::TIME_WIDTH-1:0];
                ookpw_pkg::CFG_SHORT_TOLERANCE:
                    cfg_next.short_tolerance = cfg.data[ookpw_pkg::TIME_WIDTH-1:0];
                ookpw_pkg::CFG_LONG_TOLERANCE:
                    cfg_next.long_tolerance = cfg.data[ookpw_pkg::TIME_WIDTH-1:0];
                ookpw_pkg::CFG_PREAMBLE_WINDOW:
                    cfg_next.preamble_window = cfg.data[ookpw_pkg::DURATION_WIDTH-1:0];
                ookpw_pkg::CFG_GAP_THRESHOLD:
                    cfg_next.gap_threshold = cfg.data[ookpw_pkg::DURATION_WIDTH-1:0];
                ookpw_pkg::CFG_MIN_BITS:
                    cfg_next.min_bits = cfg.data[ookpw_pkg::COUNT_WIDTH-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_time      <= ookpw_pkg::RST_SHORT_TIME;
            cfg_reg.long_time       <= ookpw_pkg::RST_LONG_TIME;
            cfg_reg.short_tolerance <= ookpw_pkg::RST_SHORT_TOLERANCE;
            cfg_reg.long_tolerance  <= ookpw_pkg::RST_LONG_TOLERANCE;
            cfg_reg.preamble_window <= ookpw_pkg::RST_PREAMBLE_WINDOW;
            cfg_reg.gap_threshold   <= ookpw_pkg::RST_GAP_THRESHOLD;
            cfg_reg.min_bits        <= ookpw_pkg::RST_MIN_BITS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ookpw_classify.sv @@
// Pulse width classifier: tolerance windows and gap compare, purely combinational.
// Depends on ookpw_pkg.
`default_nettype none

module ookpw_classify
(
    input  wire ookpw_pkg::cfg_t                      cfg_values,
    input  wire logic [ookpw_pkg::DURATION_WIDTH-1:0] duration,
    input  wire logic [ookpw_pkg::DURATION_WIDTH-1:0] last_low,
    output ookpw_pkg::match_t                         match
);

    logic [ookpw_pkg::DURATION_WIDTH-1:0] short_t;
    logic [ookpw_pkg::DURATION_WIDTH-1:0] long_t;
    logic [ookpw_pkg::DURATION_WIDTH-1:0] short_tol;
    logic [ookpw_pkg::DURATION_WIDTH-1:0] long_tol;

    // Widen the 16-bit timing registers to duration width
    assign short_t   = ookpw_pkg::DURATION_WIDTH'(cfg_values.short_time);
    assign long_t    = ookpw_pkg::DURATION_WIDTH'(cfg_values.long_time);
    assign short_tol = ookpw_pkg::DURATION_WIDTH'(cfg_values.short_tolerance);
    assign long_tol  = ookpw_pkg::DURATION_WIDTH'(cfg_values.long_tolerance);

    // Window compares
    assign match.pre_arm   = ookpw_pkg::near(duration, short_t, cfg_values.preamble_window);
    assign match.dur_long  = ookpw_pkg::near(duration, long_t, long_tol);
    assign match.dur_short = ookpw_pkg::near(duration, short_t, short_tol);
    assign match.low_long  = ookpw_pkg::near(last_low, long_t, long_tol);
    assign match.low_short = ookpw_pkg::near(last_low, short_t, short_tol);
    assign match.gap       = (duration >= cfg_values.gap_threshold);

endmodule

`default_nettype wire

@@ rtl/core/ookpw_parser.sv @@
// Frame parser: state machine, shift register, bit count and result register.
// Depends on ookpw_pkg; match flags come from ookpw_classify.
`default_nettype none

module ookpw_parser
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 fire,
    input  wire logic                                 level,
    input  wire logic [ookpw_pkg::DURATION_WIDTH-1:0] duration,
    input  wire ookpw_pkg::match_t                    match,
    input  wire logic [ookpw_pkg::COUNT_WIDTH-1:0]    min_bits,
    input  wire logic                                 out_ready,
    output logic [ookpw_pkg::DURATION_WIDTH-1:0]      last_low,
    output logic                                      out_valid,
    output logic [ookpw_pkg::DATA_WIDTH-1:0]          frame_data,
    output logic [ookpw_pkg::COUNT_WIDTH-1:0]         frame_bits
);

    ookpw_pkg::state_t                   state_reg, state_next;
    logic [ookpw_pkg::DURATION_WIDTH-1:0] last_low_reg, last_low_next;
    logic [ookpw_pkg::DATA_WIDTH-1:0]     shift_reg, shift_next;
    logic [ookpw_pkg::COUNT_WIDTH-1:0]    count_reg, count_next;
    logic                                 out_valid_reg, out_valid_next;
    logic [ookpw_pkg::DATA_WIDTH-1:0]     frame_data_reg;
    logic [ookpw_pkg::COUNT_WIDTH-1:0]    frame_bits_reg;
    logic                                 emit;
    logic                                 push;
    logic                                 push_bit;
    logic [ookpw_pkg::COUNT_WIDTH-1:0]    count_inc;

    assign last_low   = last_low_reg;
    assign out_valid  = out_valid_reg;
    assign frame_data = frame_data_reg;
    assign frame_bits = frame_bits_reg;

    // Saturating count
    assign count_inc = (count_reg == ookpw_pkg::COUNT_MAX) ? count_reg : count_reg + 1'b1;

    // Parser next state
    always_comb
    begin
        state_next    = state_reg;
        last_low_next = last_low_reg;
        shift_next    = shift_reg;
        count_next    = count_reg;
        emit          = 1'b0;
        push          = 1'b0;
        push_bit      = 1'b0;
        if (fire)
        begin
            unique case (state_reg)
                ookpw_pkg::ST_IDLE:
                begin
                    if (!level && match.pre_arm)
                        state_next = ookpw_pkg::ST_ARMED;
                end
                ookpw_pkg::ST_ARMED:
                begin
                    // start bit: clear, then a single 0
                    if (level && match.dur_long)
                    begin
                        state_next = ookpw_pkg::ST_SAVE;
                        shift_next = '0;
                        count_next = ookpw_pkg::COUNT_WIDTH'(1);
                    end
                    else
                    begin
                        state_next = ookpw_pkg::ST_IDLE;
                    end
                end
                ookpw_pkg::ST_SAVE:
                begin
                    // high pulses here are ignored
                    if (!level)
                    begin
                        if (match.gap)
                        begin
                            state_next = ookpw_pkg::ST_ARMED;
                            emit       = (count_reg >= min_bits);
                            shift_next = '0;
                            count_next = '0;
                        end
                        else
                        begin
                            last_low_next = duration;
                            state_next    = ookpw_pkg::ST_CHECK;
                        end
                    end
                end
                ookpw_pkg::ST_CHECK:
                begin
                    if (level && match.low_short && match.dur_long)
                    begin
                        push       = 1'b1;
                        push_bit   = 1'b0;
                        state_next = ookpw_pkg::ST_SAVE;
                    end
                    else if (level && match.low_long && match.dur_short)
                    begin
                        push       = 1'b1;
                        push_bit   = 1'b1;
                        state_next = ookpw_pkg::ST_SAVE;
                    end
                    else
                    begin
                        state_next = ookpw_pkg::ST_IDLE;
                    end
                end
                default:
                    state_next = ookpw_pkg::ST_IDLE;
            endcase
        end
        if (push)
        begin
            shift_next = {shift_reg[ookpw_pkg::DATA_WIDTH-2:0], push_bit};
            count_next = count_inc;
        end
    end

    // Result register: loads on a report, drops on a transfer
    assign out_valid_next = emit | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ookpw_pkg::ST_IDLE;
            last_low_reg  <= '0;
            shift_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_low_reg  <= last_low_next;
            shift_reg     <= shift_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            frame_data_reg <= shift_reg;
            frame_bits_reg <= count_reg;
        end
    end

    // Checks
    a_clear_after_gap: assert property (@(posedge clk) disable iff (!rst_n)
        fire && state_reg == ookpw_pkg::ST_SAVE && !level && match.gap
        |=> count_reg == '0 && shift_reg == '0 && state_reg == ookpw_pkg::ST_ARMED)
        else $error("parser did not clear and rearm at frame gap");

    a_hold_without_fire: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(state_reg) && $stable(count_reg) && $stable(shift_reg))
        else $error("parser state moved without a pulse");

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg == $past(count_reg) || count_reg == '0
                 || count_reg == ookpw_pkg::COUNT_WIDTH'(1)
                 || count_reg == $past(count_reg) + 1'b1)
        else $error("bit count jumped");

    a_report_meets_min: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg && frame_bits_reg >= $past(min_bits))
        else $error("short frame reported");

endmodule

`default_nettype wire

@@ rtl/core/ook_pulse_width_frame_decoder_core.sv @@
// OOK pulse-width frame decoder, top level: input register, classifier, parser.
// A pulse is held in the input register; a pulse that ends a frame loads the result register.
// Throughput: one pulse per cycle; only a held result that is not taken stalls the input.
// Reset (rst_n low, asynchronous): parser idle, count and shift register cleared,
// configuration back to its defaults, no result pending.
// Depends on ookpw_pkg, ookpw_ifs, ookpw_cfg_regs, ookpw_classify, ookpw_parser.
`default_nettype none

module ook_pulse_width_frame_decoder_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    ookpw_pulse_if.sink      pulse,
    ookpw_frame_if.source    frame,
    ookpw_cfg_if.sink        cfg
);

    ookpw_pkg::cfg_t                      cfg_values;
    ookpw_pkg::match_t                    match;
    logic                                 in_valid_reg;
    logic                                 level_reg;
    logic [ookpw_pkg::DURATION_WIDTH-1:0] duration_reg;
    logic [ookpw_pkg::DURATION_WIDTH-1:0] last_low;
    logic                                 out_valid;
    logic                                 fire;
    logic                                 in_take;

    // Pulse in the input register is processed when the result slot is free
    assign fire        = in_valid_reg & (~out_valid | frame.ready);
    assign pulse.ready = ~in_valid_reg | fire;
    assign in_take     = pulse.valid & pulse.ready;
    assign frame.valid = out_valid;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (pulse.ready)
            in_valid_reg <= pulse.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            level_reg    <= pulse.level;
            duration_reg <= pulse.duration;
        end
    end

    ookpw_cfg_regs u_cfg_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cfg_values (cfg_values)
    );

    ookpw_classify u_classify
    (
        .cfg_values (cfg_values),
        .duration   (duration_reg),
        .last_low   (last_low),
        .match      (match)
    );

    ookpw_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .level      (level_reg),
        .duration   (duration_reg),
        .match      (match),
        .min_bits   (cfg_values.min_bits),
        .out_ready  (frame.ready),
        .last_low   (last_low),
        .out_valid  (out_valid),
        .frame_data (frame.frame_data),
        .frame_bits (frame.frame_bits)
    );

endmodule

`default_nettype wire
